/* sv/hashed_name_store_with_rate_limit_macros.svh */
// assertion macros for the hashed name store
// needs a clock named clk and a reset named rst in the module that expands them
`ifndef HASHED_NAME_STORE_WITH_RATE_LIMIT_MACROS_SVH
`define HASHED_NAME_STORE_WITH_RATE_LIMIT_MACROS_SVH

// same-cycle implication
`define HNSRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HNSRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hnsrl_pkg.sv */
// shared types and constants of the hashed name store
// no dependencies
package hnsrl_pkg;

  // transaction payloads
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  key_length;
    logic [31:0] source_ip;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] id_byte;
    logic       last_result;
  } rsp_t;

  // opcodes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_KEY      = 2'd2;
  localparam logic [1:0] OP_CLEAR_IP = 2'd3;

  // result codes
  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_RATE      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // fixed sizes
  localparam int BUCKET_BITS = 16;
  localparam int BUF_W       = 9;
  localparam logic [3:0] LIMIT_RESET = 4'd15;

  // control between sequencer and ip table
  typedef struct packed {
    logic start;
    logic clear;
  } ip_ctl_t;

  typedef struct packed {
    logic done;
    logic allow;
  } ip_sts_t;

endpackage

/* sv/hnsrl_ip_table.sv */
// per-source request counters, searched one slot at a time, each slot read and then checked
// depends on hnsrl_pkg and the assertion macro header
`include "hashed_name_store_with_rate_limit_macros.svh"
module hnsrl_ip_table import hnsrl_pkg::*; #(
  parameter int IP_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  ip_ctl_t     ctl,
  input  logic [31:0] ip,
  input  logic [3:0]  limit,
  output ip_sts_t     sts
);

  localparam int SW = (IP_SLOTS > 1) ? $clog2(IP_SLOTS) : 1;

  typedef struct packed {
    logic [31:0] ip;
    logic [3:0]  count;
  } slot_t;

  typedef enum logic [3:0] {
    I_IDLE = 4'b0001,
    I_RD   = 4'b0010,
    I_CHK  = 4'b0100,
    I_DONE = 4'b1000
  } ist_t;

  ist_t        ist;
  logic [SW:0] fill;
  logic [SW:0] idx;
  logic        allow;
  slot_t       mem [IP_SLOTS];
  slot_t       q;
  logic [SW:0] addr;
  logic        we;
  slot_t       wdata;

  // memory port selection
  always_comb begin
    addr  = idx;
    we    = 1'b0;
    wdata = '{ip: ip, count: 4'd0};
    unique case (ist)
      I_RD: begin
        if (idx == fill && fill < (SW+1)'(IP_SLOTS)) begin
          addr = fill;
          we   = 1'b1;
        end
      end
      I_CHK: begin
        if (q.ip == ip && q.count < limit) begin
          we    = 1'b1;
          wdata = '{ip: ip, count: q.count + 4'd1};
        end
      end
      default: ;
    endcase
  end

  // slot store
  always_ff @(posedge clk) begin
    if (we) mem[addr[SW-1:0]] <= wdata;
    q <= mem[addr[SW-1:0]];
  end

  // search sequencer; live slots always form a prefix of length fill
  always_ff @(posedge clk) begin
    if (rst) begin
      ist  <= I_IDLE;
      fill <= '0;
    end else begin
      unique case (ist)
        I_IDLE: begin
          if (ctl.clear) fill <= '0;
          if (ctl.start) begin
            idx <= '0;
            ist <= I_RD;
          end
        end
        I_RD: begin
          if (idx == fill) begin
            allow <= (fill < (SW+1)'(IP_SLOTS));
            if (fill < (SW+1)'(IP_SLOTS)) fill <= fill + 1'b1;
            ist <= I_DONE;
          end else begin
            ist <= I_CHK;
          end
        end
        I_CHK: begin
          if (q.ip == ip) begin
            allow <= (q.count < limit);
            ist   <= I_DONE;
          end else begin
            idx <= idx + 1'b1;
            ist <= I_RD;
          end
        end
        I_DONE: ist <= I_IDLE;
        default: ist <= I_IDLE;
      endcase
    end
  end

  assign sts = '{done: (ist == I_DONE), allow: allow};

  `HNSRL_ASSERT_NOW(a_fill_bound, 1'b1, fill <= (SW+1)'(IP_SLOTS), "ip fill beyond slot count")
  `HNSRL_ASSERT_NEXT(a_done_pulse, sts.done, !sts.done, "ip done longer than one cycle")
  `HNSRL_ASSERT_NOW(a_ctl_idle, ctl.start || ctl.clear, ist == I_IDLE, "ip table busy on request")

endmodule

/* sv/hashed_name_store_with_rate_limit.sv */
// top level of the hashed name store: sequencer, bucket heads, entry store, key buffer
// depends on hnsrl_pkg, hnsrl_ip_table and the assertion macro header
//
// channel | direction | handshake                | payload
// req     | in        | req_valid / req_stall    | req_t
// rsp     | out       | rsp_valid / rsp_stall    | rsp_t
// cfg     | in        | cfg_we                   | cfg_wdata (request limit)
//
// a key byte or begin is taken while the sequencer is idle; the closing byte starts a walk
// on the single-port entry store, one byte compared or copied at a time, plus a search
// of the ip slots for inserts and four link reads per chain step.
// after reset a clearing pass over all 65536 bucket heads empties them; req is
// stalled meanwhile. results wait in one output register under rsp_stall.
`include "hashed_name_store_with_rate_limit_macros.svh"
module hashed_name_store_with_rate_limit import hnsrl_pkg::*; #(
  parameter int STORE_BYTES = 65536,
  parameter int ID_BYTES    = 38,
  parameter int IP_SLOTS    = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int NW = AW + 2;
  localparam int BUCKETS = 1 << BUCKET_BITS;

  typedef enum logic [18:0] {
    S_CLEAR    = 19'b0000000000000000001,
    S_IDLE     = 19'b0000000000000000010,
    S_IP       = 19'b0000000000000000100,
    S_HEAD_RD  = 19'b0000000000000001000,
    S_HEAD_CHK = 19'b0000000000000010000,
    S_ENT      = 19'b0000000000000100000,
    S_LEN_CHK  = 19'b0000000000001000000,
    S_NAME_RD  = 19'b0000000000010000000,
    S_NAME_CHK = 19'b0000000000100000000,
    S_LNK_RD   = 19'b0000000001000000000,
    S_LNK_CHK  = 19'b0000000010000000000,
    S_FIT      = 19'b0000000100000000000,
    S_TAIL_WR  = 19'b0000001000000000000,
    S_HDR_WR   = 19'b0000010000000000000,
    S_BODY_RD  = 19'b0000100000000000000,
    S_BODY_WR  = 19'b0001000000000000000,
    S_ID_RD    = 19'b0010000000000000000,
    S_ID_EMIT  = 19'b0100000000000000000,
    S_RESULT   = 19'b1000000000000000000
  } state_t;

  state_t                  state;
  logic [3:0]              limit;
  logic                    pend_act;
  logic                    pend_ins;
  logic                    run_ins;
  logic [7:0]              len;
  logic [31:0]             ip;
  logic [BUCKET_BITS-1:0]  hash;
  logic [BUF_W-1:0]        cnt;
  logic [BUF_W-1:0]        idx;
  logic [AW-1:0]           ent;
  logic                    tail_ok;
  logic [23:0]             lnk;
  logic [AW:0]             app;
  logic [2:0]              res_status;
  logic [BUCKET_BITS-1:0]  clr_addr;
  logic                    ip_start;
  rsp_t                    rsp_q;

  // memories and their ports
  logic [AW:0]             hd_mem [BUCKETS];
  logic [AW:0]             hd_q;
  logic [BUCKET_BITS-1:0]  hd_addr;
  logic                    hd_we;
  logic [AW:0]             hd_wdata;
  logic [7:0]              st_mem [STORE_BYTES];
  logic [7:0]              st_q;
  logic [AW-1:0]           st_addr;
  logic                    st_we;
  logic [7:0]              st_wdata;
  logic [7:0]              buf_mem [1 << BUF_W];
  logic [7:0]              buf_q;
  logic [BUF_W-1:0]        buf_raddr;
  logic                    buf_we;

  ip_ctl_t                 ip_ctl;
  ip_sts_t                 ip_sts;

  logic                    req_acc;
  logic                    out_free;
  logic                    rsp_load;
  logic [AW-1:0]           app_a;
  logic [31:0]             app_32;
  logic [31:0]             nx;
  logic [NW-1:0]           need;
  logic [NW-1:0]           room;
  logic [BUF_W-1:0]        cnt_next;
  logic [BUF_W-1:0]        total;
  logic [BUF_W-1:0]        body_last;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign app_a     = app[AW-1:0];
  assign app_32    = {{(32-AW){1'b0}}, app_a};
  assign nx        = {st_q, lnk};
  assign need      = NW'(5) + NW'(len) + NW'(ID_BYTES);
  assign room      = NW'(STORE_BYTES) - NW'(app);
  assign cnt_next  = cnt + 1'b1;
  assign total     = BUF_W'(len) + (pend_ins ? BUF_W'(ID_BYTES) : '0);
  assign body_last = BUF_W'(len) + BUF_W'(ID_BYTES - 1);
  assign rsp_load  = out_free && ((state == S_ID_EMIT) || (state == S_RESULT));

  // port selection for the memories
  always_comb begin
    hd_addr   = hash;
    hd_we     = 1'b0;
    hd_wdata  = {1'b1, app_a};
    st_addr   = ent + AW'(4);
    st_we     = 1'b0;
    st_wdata  = 8'hFF;
    buf_raddr = idx;
    buf_we    = req_acc && req.opcode == OP_KEY && pend_act;
    unique case (state)
      S_CLEAR: begin
        hd_addr  = clr_addr;
        hd_we    = 1'b1;
        hd_wdata = '0;
      end
      S_NAME_RD:  st_addr = ent + AW'(5) + AW'(idx);
      S_LNK_RD:   st_addr = ent + AW'(idx[1:0]);
      S_FIT:      hd_we = (need <= room) && !tail_ok;
      S_TAIL_WR: begin
        st_addr  = ent + AW'(idx[1:0]);
        st_we    = 1'b1;
        st_wdata = app_32[idx[1:0]*8 +: 8];
      end
      S_HDR_WR: begin
        st_addr  = app_a + AW'(idx);
        st_we    = 1'b1;
        st_wdata = (idx == BUF_W'(4)) ? len : 8'hFF;
      end
      S_BODY_WR: begin
        st_addr  = app_a + AW'(5) + AW'(idx);
        st_we    = 1'b1;
        st_wdata = buf_q;
      end
      S_ID_RD, S_ID_EMIT: st_addr = ent + AW'(5) + AW'(len) + AW'(idx);
      default: ;
    endcase
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (hd_we) hd_mem[hd_addr] <= hd_wdata;
    hd_q <= hd_mem[hd_addr];
  end

  // entry store
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_addr] <= st_wdata;
    st_q <= st_mem[st_addr];
  end

  // name and id buffer, byte k of the operation at address k
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[cnt] <= req.data_byte;
    buf_q <= buf_mem[buf_raddr];
  end

  // request limit register
  always_ff @(posedge clk) begin
    if (rst) limit <= LIMIT_RESET;
    else if (cfg_we) limit <= cfg_wdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      if (state == S_ID_EMIT) begin
        rsp_q <= '{status: ST_FOUND, id_byte: st_q,
                   last_result: (idx == BUF_W'(ID_BYTES - 1))};
      end else begin
        rsp_q <= '{status: res_status, id_byte: 8'd0, last_result: 1'b1};
      end
    end
  end
  assign rsp = rsp_q;

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pend_act <= 1'b0;
      cnt      <= '0;
      app      <= '0;
      ip_start <= 1'b0;
    end else begin
      ip_start <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BUCKET_BITS'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_acc) begin
            unique case (req.opcode)
              OP_INSERT, OP_LOOKUP: begin
                pend_ins <= (req.opcode == OP_INSERT);
                len      <= req.key_length;
                ip       <= req.source_ip;
                hash     <= '0;
                cnt      <= '0;
                if (req.opcode == OP_LOOKUP && req.key_length == 8'd0) begin
                  pend_act <= 1'b0;
                  run_ins  <= 1'b0;
                  state    <= S_HEAD_RD;
                end else begin
                  pend_act <= 1'b1;
                end
              end
              OP_KEY: begin
                if (pend_act) begin
                  if (cnt < BUF_W'(len) && cnt < BUF_W'(4)) begin
                    hash[cnt[1:0]*4 +: 4] <= req.data_byte[3:0];
                  end
                  cnt <= cnt_next;
                  if (cnt_next >= total) begin
                    pend_act <= 1'b0;
                    run_ins  <= pend_ins;
                    cnt      <= '0;
                    if (pend_ins) begin
                      ip_start <= 1'b1;
                      state    <= S_IP;
                    end else begin
                      state <= S_HEAD_RD;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_IP: begin
          if (ip_sts.done) begin
            if (ip_sts.allow) begin
              state <= S_HEAD_RD;
            end else begin
              res_status <= ST_RATE;
              state      <= S_RESULT;
            end
          end
        end
        S_HEAD_RD: state <= S_HEAD_CHK;
        S_HEAD_CHK: begin
          tail_ok <= hd_q[AW];
          if (hd_q[AW]) begin
            ent   <= hd_q[AW-1:0];
            state <= S_ENT;
          end else if (run_ins) begin
            state <= S_FIT;
          end else begin
            res_status <= ST_NOT_FOUND;
            state      <= S_RESULT;
          end
        end
        S_ENT: state <= S_LEN_CHK;
        S_LEN_CHK: begin
          idx <= '0;
          if (st_q != len) begin
            state <= S_LNK_RD;
          end else if (len == 8'd0) begin
            if (run_ins) begin
              res_status <= ST_EXISTS;
              state      <= S_RESULT;
            end else begin
              state <= S_ID_RD;
            end
          end else begin
            state <= S_NAME_RD;
          end
        end
        S_NAME_RD: state <= S_NAME_CHK;
        S_NAME_CHK: begin
          if (st_q != buf_q) begin
            idx   <= '0;
            state <= S_LNK_RD;
          end else if (idx == BUF_W'(len) - 1'b1) begin
            idx <= '0;
            if (run_ins) begin
              res_status <= ST_EXISTS;
              state      <= S_RESULT;
            end else begin
              state <= S_ID_RD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_NAME_RD;
          end
        end
        S_LNK_RD: state <= S_LNK_CHK;
        S_LNK_CHK: begin
          if (idx[1:0] == 2'd3) begin
            // end of chain on no link or a link that does not point forward
            if (nx == 32'hFFFF_FFFF || nx <= {{(32-AW){1'b0}}, ent}) begin
              if (run_ins) begin
                state <= S_FIT;
              end else begin
                res_status <= ST_NOT_FOUND;
                state      <= S_RESULT;
              end
            end else begin
              ent   <= nx[AW-1:0];
              state <= S_ENT;
            end
          end else begin
            lnk[idx[1:0]*8 +: 8] <= st_q;
            idx   <= idx + 1'b1;
            state <= S_LNK_RD;
          end
        end
        S_FIT: begin
          idx <= '0;
          if (need > room) begin
            res_status <= ST_FULL;
            state      <= S_RESULT;
          end else if (tail_ok) begin
            state <= S_TAIL_WR;
          end else begin
            state <= S_HDR_WR;
          end
        end
        S_TAIL_WR: begin
          if (idx[1:0] == 2'd3) begin
            idx   <= '0;
            state <= S_HDR_WR;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_HDR_WR: begin
          if (idx == BUF_W'(4)) begin
            idx   <= '0;
            state <= S_BODY_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_BODY_RD: state <= S_BODY_WR;
        S_BODY_WR: begin
          if (idx == body_last) begin
            app        <= app + (AW+1)'(need);
            res_status <= ST_STORED;
            state      <= S_RESULT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_BODY_RD;
          end
        end
        S_ID_RD: state <= S_ID_EMIT;
        S_ID_EMIT: begin
          if (out_free) begin
            if (idx == BUF_W'(ID_BYTES - 1)) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ID_RD;
            end
          end
        end
        S_RESULT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // rate check unit
  assign ip_ctl = '{start: ip_start,
                    clear: req_acc && req.opcode == OP_CLEAR_IP};

  hnsrl_ip_table #(
    .IP_SLOTS (IP_SLOTS)
  ) u_ip_table (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ip_ctl),
    .ip    (ip),
    .limit (limit),
    .sts   (ip_sts)
  );

  `HNSRL_ASSERT_NOW(a_single_last, rsp_valid && rsp.status != ST_FOUND, rsp.last_result, "non-found result not last")
  `HNSRL_ASSERT_NOW(a_id_zero, rsp_valid && rsp.status != ST_FOUND, rsp.id_byte == 8'd0, "id byte set without a hit")
  `HNSRL_ASSERT_NOW(a_app_bound, 1'b1, app <= (AW+1)'(STORE_BYTES), "append offset beyond store")
  `HNSRL_ASSERT_NEXT(a_ip_leave, state == S_IP && ip_sts.done, state != S_IP, "sequencer stuck after rate check")

endmodule

/* bench/hashed_name_store_with_rate_limit_tb.sv */
// self-checking testbench for the hashed name store with per-source rate limit
// depends on hnsrl_pkg and the hashed_name_store_with_rate_limit rtl
`timescale 1ns / 1ps

module hashed_name_store_with_rate_limit_tb;
  import hnsrl_pkg::*;

  localparam int STORE_N = 65536;
  localparam int ID_N    = 38;
  localparam int IP_N    = 256;
  localparam logic [31:0] NO_LINK = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {PEND_IDLE, PEND_INSERT, PEND_LOOKUP} pend_kind_t;

  // name store predictor with its queue of expected results
  class name_store_scoreboard;
    rsp_t        expected_q[$];
    int          mismatches;
    int          checked;
    logic [3:0]  limit;
    logic [7:0]  store_mem[STORE_N];
    logic [31:0] head_of[65536];
    bit          head_ok[65536];
    int unsigned append_at;
    logic [7:0]  name_buf[256];
    logic [7:0]  id_buf[ID_N];
    bit          slot_ok[IP_N];
    logic [31:0] slot_addr[IP_N];
    logic [3:0]  slot_cnt[IP_N];
    pend_kind_t  pend_kind;
    int unsigned pend_len;
    logic [31:0] pend_ip;
    logic [15:0] pend_hash;
    int unsigned byte_cnt;

    function new();
      limit = LIMIT_RESET;
      append_at = 0;
      pend_kind = PEND_IDLE;
      pend_len = 0;
      pend_ip = 0;
      pend_hash = 0;
      byte_cnt = 0;
      mismatches = 0;
      checked = 0;
      foreach (head_ok[i]) head_ok[i] = 0;
      foreach (slot_ok[i]) slot_ok[i] = 0;
    endfunction

    function logic [7:0] rd(int unsigned a);
      return (a < STORE_N) ? store_mem[a] : 8'd0;
    endfunction

    function void wr(int unsigned a, logic [7:0] v);
      if (a < STORE_N) store_mem[a] = v;
    endfunction

    function logic [31:0] link_at(int unsigned e);
      return {rd(e + 3), rd(e + 2), rd(e + 1), rd(e)};
    endfunction

    function void put_link(int unsigned e, logic [31:0] v);
      for (int i = 0; i < 4; i++) wr(e + i, v[8*i +: 8]);
    endfunction

    function bit name_matches(int unsigned e);
      if (rd(e + 4) != pend_len[7:0]) return 0;
      for (int unsigned i = 0; i < pend_len; i++)
        if (rd(e + 5 + i) != name_buf[i]) return 0;
      return 1;
    endfunction

    // walk the chain; on a miss hit holds the tail
    function bit find_in_chain(output int unsigned hit);
      int unsigned e;
      logic [31:0] nx;
      hit = 0;
      if (!head_ok[pend_hash]) return 0;
      e = head_of[pend_hash];
      forever begin
        hit = e;
        if (name_matches(e)) return 1;
        nx = link_at(e);
        if (nx == NO_LINK || nx <= e) return 0;
        e = nx;
      end
    endfunction

    function bit ip_admit(logic [31:0] ip);
      for (int i = 0; i < IP_N; i++)
        if (slot_ok[i] && slot_addr[i] == ip) begin
          if (slot_cnt[i] >= limit) return 0;
          slot_cnt[i]++;
          return 1;
        end
      for (int i = 0; i < IP_N; i++)
        if (!slot_ok[i]) begin
          slot_ok[i] = 1;
          slot_addr[i] = ip;
          slot_cnt[i] = 0;
          return 1;
        end
      return 0;
    endfunction

    function logic [2:0] insert_entry();
      int unsigned tail, need, a;
      if (!ip_admit(pend_ip)) return ST_RATE;
      if (find_in_chain(tail)) return ST_EXISTS;
      need = 5 + pend_len + ID_N;
      if (append_at > STORE_N || need > STORE_N - append_at) return ST_FULL;
      a = append_at;
      if (head_ok[pend_hash]) put_link(tail, a);
      else begin
        head_of[pend_hash] = a;
        head_ok[pend_hash] = 1;
      end
      put_link(a, NO_LINK);
      wr(a + 4, pend_len[7:0]);
      for (int unsigned i = 0; i < pend_len; i++) wr(a + 5 + i, name_buf[i]);
      for (int unsigned i = 0; i < ID_N; i++) wr(a + 5 + pend_len + i, id_buf[i]);
      append_at = a + need;
      return ST_STORED;
    endfunction

    function void complete();
      int unsigned e;
      pend_kind_t k;
      k = pend_kind;
      pend_kind = PEND_IDLE;
      if (k == PEND_INSERT)
        expected_q.push_back('{status: insert_entry(), id_byte: 8'd0, last_result: 1'b1});
      else if (find_in_chain(e))
        for (int unsigned i = 0; i < ID_N; i++)
          expected_q.push_back('{status: ST_FOUND, id_byte: rd(e + 5 + pend_len + i),
                                 last_result: (i + 1 == ID_N)});
      else
        expected_q.push_back('{status: ST_NOT_FOUND, id_byte: 8'd0, last_result: 1'b1});
      pend_len = 0;
      pend_ip = 0;
      pend_hash = 0;
      byte_cnt = 0;
    endfunction

    function void note_request(req_t r);
      int unsigned total;
      case (r.opcode)
        OP_CLEAR_IP: begin
          foreach (slot_ok[i]) slot_ok[i] = 0;
          foreach (slot_cnt[i]) slot_cnt[i] = 0;
        end
        OP_INSERT, OP_LOOKUP: begin
          pend_kind = (r.opcode == OP_INSERT) ? PEND_INSERT : PEND_LOOKUP;
          pend_len = r.key_length;
          pend_ip = (r.opcode == OP_INSERT) ? r.source_ip : 32'd0;
          pend_hash = 0;
          byte_cnt = 0;
          if (r.opcode == OP_LOOKUP && pend_len == 0) complete();
        end
        default: begin
          if (pend_kind != PEND_IDLE) begin
            if (byte_cnt < pend_len) begin
              name_buf[byte_cnt] = r.data_byte;
              if (byte_cnt < 4) pend_hash[4*byte_cnt +: 4] = r.data_byte[3:0];
            end else if (byte_cnt - pend_len < ID_N) begin
              id_buf[byte_cnt - pend_len] = r.data_byte;
            end
            byte_cnt++;
            total = pend_len + ((pend_kind == PEND_INSERT) ? ID_N : 0);
            if (byte_cnt >= total) complete();
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.id_byte !== want.id_byte)
        report($sformatf("id_byte %0h, expected %0h", got.id_byte, want.id_byte));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result %0b, expected %0b", got.last_result,
                         want.last_result));
    endtask
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       req_valid = 0;
  logic       req_stall;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 0;
  rsp_t       rsp;
  logic       cfg_we = 0;
  logic [3:0] cfg_wdata = 0;

  name_store_scoreboard sb = new();
  bit         steady = 0;
  bit         want_hold = 0;
  int         hold_left = 0;
  int         items_sent = 0;
  logic [7:0] name_bytes[256];

  hashed_name_store_with_rate_limit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // overall time limit
  initial begin
    #32ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver stalls, with a long hold-off on request
  always @(negedge clk) begin
    if (want_hold) begin
      want_hold = 0;
      hold_left = 400;
    end
    if (rst) rsp_stall = 0;
    else if (hold_left > 0) begin
      rsp_stall = 1;
      hold_left--;
    end else rsp_stall = !steady && ($urandom_range(99) < 36);
  end

  // result monitor
  always @(posedge clk)
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);

  // one transaction on the request channel
  task send(logic [1:0] op, logic [7:0] len, logic [31:0] ip, logic [7:0] b);
    @(negedge clk);
    if (!steady)
      while ($urandom_range(99) < 36) begin
        req_valid = 0;
        @(negedge clk);
      end
    req_valid = 1;
    req = '{opcode: op, key_length: len, source_ip: ip, data_byte: b};
    do @(posedge clk); while (req_stall);
    sb.note_request(req);
    items_sent++;
  endtask

  task key_byte(logic [7:0] b);
    send(OP_KEY, 8'($urandom), $urandom, b);
  endtask

  // name bytes from a seed
  task make_name(int seed, int len);
    for (int i = 0; i < len; i++) name_bytes[i] = 8'(seed * 131 + i * 29 + (seed >> 3) * i);
  endtask

  task insert_name(int len, logic [31:0] ip);
    send(OP_INSERT, 8'(len), ip, 8'($urandom));
    for (int i = 0; i < len; i++) key_byte(name_bytes[i]);
    for (int i = 0; i < ID_N; i++) key_byte(8'($urandom));
  endtask

  task lookup_name(int len);
    send(OP_LOOKUP, 8'(len), $urandom, 8'($urandom));
    for (int i = 0; i < len; i++) key_byte(name_bytes[i]);
  endtask

  task drain();
    @(negedge clk);
    req_valid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task write_limit(logic [3:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.limit = v;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // stored entry and its lookup
    write_limit(4'd15);
    make_name(1, 2);
    insert_name(2, 32'h0000_0000);
    lookup_name(2);
    // same hash, different name, appended to the chain with no idling
    name_bytes[0] = name_bytes[0] ^ 8'h80;
    steady = 1;
    insert_name(2, 32'hFFFF_FFFF);
    steady = 0;
    // long receiver hold-off while further transactions are offered
    want_hold = 1;
    lookup_name(2);
    lookup_name(0);
    key_byte(8'hFF);
    send(OP_INSERT, 8'd3, 32'h77, 8'h00);
    key_byte(8'h11);
    drain();

    // rate limit of zero after clearing the source table
    write_limit(4'd0);
    send(OP_CLEAR_IP, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // new source passes, name already present
    insert_name(2, 32'h1);
    // known source at the limit is refused
    insert_name(0, 32'h1);
    drain();

    $display("%0d request transactions sent, %0d results checked", items_sent, sb.checked);
    $display("covered inserts, lookups, chains, duplicates, rate limits and a long hold-off");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/hnsrl_pkg.sv
sv/hnsrl_ip_table.sv
sv/hashed_name_store_with_rate_limit.sv
bench/hashed_name_store_with_rate_limit_tb.sv
